// File: design/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = 4;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [PADDR_W-1:0] ADDR_HALF_PERIOD = 3'd0;
  localparam logic [7:0]         HALF_PERIOD_RST  = 8'd5;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4
  } req_code_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START1 = 4'd1,
    PH_START2 = 4'd2,
    PH_STOP1  = 4'd3,
    PH_STOP2  = 4'd4,
    PH_WLOW   = 4'd5,
    PH_WHIGH  = 4'd6,
    PH_ALOW   = 4'd7,
    PH_AHIGH  = 4'd8,
    PH_RLOW   = 4'd9,
    PH_RHIGH  = 4'd10,
    PH_KLOW   = 4'd11,
    PH_KHIGH  = 4'd12
  } phase_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       ack_to_send;
    logic       sda_in;
  } req_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       rejected;
  } res_item_t;

endpackage

`default_nettype wire

// File: design/i2cm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic       ack_to_send;
  logic       sda_in;

  modport source (output valid, req_type, data_byte, ack_to_send, sda_in, input ready);
  modport sink   (input valid, req_type, data_byte, ack_to_send, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;
  logic       rejected;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  ack_received, rejected, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte,
                  ack_received, rejected, output ready);
endinterface

`default_nettype wire

// File: design/i2cm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [i2cm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [i2cm_pkg::PDATA_W-1:0] pwdata,
  output logic      [i2cm_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output logic      [7:0]                   half_period
);
  import i2cm_pkg::*;

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr == ADDR_HALF_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      half_period <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[7:0] = half_period;
    end
  end

endmodule

`default_nettype wire

// File: design/i2cm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire i2cm_pkg::req_item_t   item,
  input  wire logic [7:0]            half_period,
  output i2cm_pkg::res_item_t        res_next
);
  import i2cm_pkg::*;

  localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BITS_PER_BYTE);

  phase_t               phase, phase_next;
  logic [7:0]           tick_count, tick_count_next;
  logic [BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic                 pending_ack, pending_ack_next;
  logic                 scl_level, scl_level_next;
  logic                 sda_level, sda_level_next;
  logic [7:0]           last_rx, last_rx_next;
  logic                 last_ack, last_ack_next;
  logic                 done_next, rej_next;

  logic [7:0]           limit;
  logic [7:0]           tick_inc;
  logic [BIT_IDX_W-1:0] bit_inc;

  assign limit    = (half_period == 8'd0) ? 8'd1 : half_period;
  assign tick_inc = tick_count + 8'd1;
  assign bit_inc  = bit_index + BIT_IDX_W'(1);

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    pending_ack_next = pending_ack;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    last_rx_next     = last_rx;
    last_ack_next    = last_ack;
    done_next        = 1'b0;
    rej_next         = 1'b0;

    case (item.req_type)
      REQ_TICK: begin
        if (phase != PH_IDLE) begin
          if (tick_inc >= limit) begin
            tick_count_next = 8'd0;
            case (phase)
              PH_START1: begin
                sda_level_next = 1'b0;
                phase_next     = PH_START2;
              end
              PH_START2: begin
                scl_level_next = 1'b0;
                phase_next     = PH_IDLE;
                done_next      = 1'b1;
              end
              PH_STOP1: begin
                sda_level_next = 1'b1;
                phase_next     = PH_STOP2;
              end
              PH_STOP2: begin
                phase_next = PH_IDLE;
                done_next  = 1'b1;
              end
              PH_WLOW: begin
                scl_level_next = 1'b1;
                phase_next     = PH_WHIGH;
              end
              PH_WHIGH: begin
                bit_index_next = bit_inc;
                scl_level_next = 1'b0;
                if (bit_inc < BIT_LAST) begin
                  sda_level_next  = shift_byte[7];
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                  phase_next      = PH_WLOW;
                end else begin
                  // release SDA for the slave acknowledge
                  sda_level_next = 1'b1;
                  phase_next     = PH_ALOW;
                end
              end
              PH_ALOW: begin
                scl_level_next = 1'b1;
                last_ack_next  = item.sda_in;
                phase_next     = PH_AHIGH;
              end
              PH_AHIGH: begin
                scl_level_next = 1'b0;
                phase_next     = PH_IDLE;
                done_next      = 1'b1;
              end
              PH_RLOW: begin
                scl_level_next  = 1'b1;
                shift_byte_next = {shift_byte[6:0], item.sda_in};
                phase_next      = PH_RHIGH;
              end
              PH_RHIGH: begin
                bit_index_next = bit_inc;
                scl_level_next = 1'b0;
                if (bit_inc < BIT_LAST) begin
                  phase_next = PH_RLOW;
                end else begin
                  last_rx_next   = shift_byte;
                  sda_level_next = pending_ack;
                  phase_next     = PH_KLOW;
                end
              end
              PH_KLOW: begin
                scl_level_next = 1'b1;
                phase_next     = PH_KHIGH;
              end
              PH_KHIGH: begin
                scl_level_next = 1'b0;
                phase_next     = PH_IDLE;
                done_next      = 1'b1;
              end
              default: begin
                phase_next = PH_IDLE;
              end
            endcase
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      REQ_START, REQ_STOP, REQ_WRITE, REQ_READ: begin
        if (phase != PH_IDLE) begin
          rej_next = 1'b1;
        end else begin
          tick_count_next = 8'd0;
          bit_index_next  = '0;
          case (item.req_type)
            REQ_START: begin
              scl_level_next = 1'b1;
              sda_level_next = 1'b1;
              phase_next     = PH_START1;
            end
            REQ_STOP: begin
              scl_level_next = 1'b1;
              sda_level_next = 1'b0;
              phase_next     = PH_STOP1;
            end
            REQ_WRITE: begin
              scl_level_next  = 1'b0;
              sda_level_next  = item.data_byte[7];
              shift_byte_next = {item.data_byte[6:0], 1'b0};
              phase_next      = PH_WLOW;
            end
            default: begin
              shift_byte_next  = 8'd0;
              pending_ack_next = item.ack_to_send;
              scl_level_next   = 1'b0;
              sda_level_next   = 1'b1;
              phase_next       = PH_RLOW;
            end
          endcase
        end
      end
      default: begin
        // unknown code: leave the state unchanged
      end
    endcase
  end

  always_comb begin
    res_next.scl_out      = scl_level_next;
    res_next.sda_out      = sda_level_next;
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.done_res     = done_next;
    res_next.rx_byte      = last_rx_next;
    res_next.ack_received = last_ack_next;
    res_next.rejected     = rej_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= 8'd0;
      bit_index   <= '0;
      shift_byte  <= 8'd0;
      pending_ack <= 1'b0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      last_rx     <= 8'd0;
      last_ack    <= 1'b0;
    end else if (en) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      shift_byte  <= shift_byte_next;
      pending_ack <= pending_ack_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      last_rx     <= last_rx_next;
      last_ack    <= last_ack_next;
    end
  end

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    en && done_next |=> phase == PH_IDLE)
    else $error("sequence ended but phase did not return to idle");

  a_tick_below_limit: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> tick_count < limit)
    else $error("tick count reached the delay limit without advancing");

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= BIT_LAST)
    else $error("bit index ran past the byte");

  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    en && rej_next |=> $stable(phase) && $stable(tick_count))
    else $error("rejected command disturbed the sequencer");

endmodule

`default_nettype wire

// File: design/i2c_bit_level_master.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-level I2C master sequencer.
// req channel: one item per clock while req.ready is high, either a tick of the bit clock carrying the
//   sampled SDA level, or a command (start, stop, write byte, read byte).
// res channel: exactly one result per req item, in order, giving the SCL/SDA
//   levels to drive after that item, busy, a done pulse, the last received
//   byte, the last slave acknowledge and a reject flag for commands that
//   arrive while a sequence is running.
// APB port: one register, half_period at address 0, ticks per half SCL bit
//   (zero counts as one); write it only while the block is idle.
// Path: a req item is held in the input register, then its result in the
//   result register, which drives res.
//   Throughput: one item per cycle while res is not held; each step of the sequencer is a single
//   pass through next-state logic on the input register.
// Stall: while res is held, an item in the input register waits, and req can
//   take one more only into an empty input register; req.ready drops only when both are full.
// Reset: both registers empty, sequencer SCL and SDA levels released high, phase idle,
//   half_period back to 5.

module i2c_bit_level_master (
  input  wire logic                         clk,
  input  wire logic                         rst,
  i2cm_req_if.sink                          req,
  i2cm_res_if.source                        res,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [i2cm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [i2cm_pkg::PDATA_W-1:0] pwdata,
  output logic      [i2cm_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import i2cm_pkg::*;

  logic       in_valid;
  req_item_t  in_item;
  logic       in_move;
  logic       out_valid;
  res_item_t  out_item;
  res_item_t  res_next;
  logic [7:0] half_period;

  i2cm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .half_period (half_period)
  );

  i2cm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .en          (in_move),
    .item        (in_item),
    .half_period (half_period),
    .res_next    (res_next)
  );

  // advance the held item whenever the result register is free or draining
  assign in_move   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || in_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item.req_type    <= req.req_type;
      in_item.data_byte   <= req.data_byte;
      in_item.ack_to_send <= req.ack_to_send;
      in_item.sda_in      <= req.sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_move) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      out_item <= res_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.scl_out      = out_item.scl_out;
  assign res.sda_out      = out_item.sda_out;
  assign res.busy_res     = out_item.busy_res;
  assign res.done_res     = out_item.done_res;
  assign res.rx_byte      = out_item.rx_byte;
  assign res.ack_received = out_item.ack_received;
  assign res.rejected     = out_item.rejected;

endmodule

`default_nettype wire
